// ----- hw/rtl/hblm_pkg.sv -----
// shared types, constants and helpers for the heartbeat lag monitor
`timescale 1ns / 1ps

package hblm_pkg;

	// ring of outstanding beacon send times
	localparam int RING_DEPTH       = 16;
	localparam int TICKS_PER_SECOND = 1000;
	localparam int IDX_W            = $clog2(RING_DEPTH);
	localparam int CNT_W            = $clog2(RING_DEPTH + 1);
	localparam int SUM_W            = CNT_W + 1;

	// field widths
	localparam int TIME_W = 48;
	localparam int SEQ_W  = 32;
	localparam int CFG_W  = 20;

	// operation codes
	localparam logic [1:0] OP_SEND  = 2'd0;
	localparam logic [1:0] OP_ACK   = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;

	// configuration register index (paddr bit 2)
	localparam logic CFG_GRACE    = 1'b0;
	localparam logic CFG_INTERVAL = 1'b1;

	// configuration reset values
	localparam logic [CFG_W-1:0] GRACE_RST    = CFG_W'(15000);
	localparam logic [CFG_W-1:0] INTERVAL_RST = CFG_W'(4000);

	typedef struct packed {
		logic [1:0]        op;
		logic [TIME_W-1:0] now;
		logic [SEQ_W-1:0]  ack_seq;
		logic              healthy;
	} item_t;

	typedef struct packed {
		logic              sent;
		logic [SEQ_W-1:0]  sent_seq;
		logic              dropped_oldest;
		logic              ack_matched;
		logic [TIME_W-1:0] round_trip;
		logic              clock_backwards;
		logic              lag_cleared;
		logic              laggy;
		logic              reconnect;
		logic [TIME_W-1:0] lag_end_stamp;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] grace_ticks;
		logic [CFG_W-1:0] interval_ticks;
	} cfg_t;

	// slot + offset folded back into the ring, sum is below twice the depth
	function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
		if (s >= SUM_W'(RING_DEPTH)) begin
			return IDX_W'(s - SUM_W'(RING_DEPTH));
		end
		return IDX_W'(s);
	endfunction

	// difference that stops at zero when time runs backwards
	function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		return (a >= b) ? (a - b) : '0;
	endfunction

endpackage

// ----- hw/rtl/hblm_core.sv -----
// beacon ring, acknowledgement tracking and lag checks, one transfer per step
`timescale 1ns / 1ps

module hblm_core
	import hblm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic [TIME_W-1:0] stamp_ring_q [RING_DEPTH];
	logic [IDX_W-1:0]  oldest_slot_q, oldest_slot_d;
	logic [CNT_W-1:0]  outstanding_q, outstanding_d;
	logic [SEQ_W-1:0]  oldest_seq_q, oldest_seq_d;
	logic [SEQ_W-1:0]  next_seq_q, next_seq_d;
	logic [TIME_W-1:0] last_acked_q, last_acked_d;
	logic [TIME_W-1:0] lag_end_q, lag_end_d;
	logic [TIME_W-1:0] last_recon_q, last_recon_d;
	logic              acked_once_q, acked_once_d;
	logic              lag_flag_q, lag_flag_d;

	logic [SEQ_W-1:0]  seq_inc;
	logic              ring_full;
	logic [IDX_W-1:0]  wr_slot;
	logic              wr_en;
	logic [SEQ_W-1:0]  off;
	logic [CNT_W-1:0]  off_c;
	logic              ack_hit;
	logic [IDX_W-1:0]  rd_slot;
	logic [IDX_W-1:0]  adv_slot;
	logic [TIME_W-1:0] stamp;
	logic              stamp_newer;
	logic [TIME_W-1:0] rtt;
	logic [TIME_W-1:0] stale_bound;
	logic [TIME_W-1:0] stale_time;
	logic [TIME_W-1:0] since;
	logic [TIME_W-1:0] grace_w;
	logic              over_grace;
	logic              over_twice;
	logic              recon_due;

	// send side
	assign seq_inc   = next_seq_q + SEQ_W'(1);
	assign ring_full = (outstanding_q >= CNT_W'(RING_DEPTH));
	assign wr_slot   = ring_full ? oldest_slot_q :
		ring_wrap(SUM_W'(oldest_slot_q) + SUM_W'(outstanding_q));
	assign wr_en     = step && (item.op == OP_SEND) && item.healthy;

	// acknowledgement lookup
	assign off      = item.ack_seq - oldest_seq_q;
	assign off_c    = off[CNT_W-1:0];
	assign ack_hit  = (outstanding_q != '0) && (off < SEQ_W'(outstanding_q));
	assign rd_slot  = ring_wrap(SUM_W'(oldest_slot_q) + SUM_W'(off_c));
	assign adv_slot = ring_wrap(SUM_W'(oldest_slot_q) + SUM_W'(off_c) + SUM_W'(1));
	assign stamp    = stamp_ring_q[rd_slot];
	assign stamp_newer = !acked_once_q || (stamp > last_acked_q);
	assign rtt      = sat_sub(item.now, stamp);
	assign grace_w  = TIME_W'(cfg.grace_ticks);
	assign stale_bound = grace_w + TIME_W'(TICKS_PER_SECOND);
	assign stale_time  = sat_sub(item.now, stale_bound);

	// lag check
	assign since      = sat_sub(item.now, last_acked_q);
	assign over_grace = (since > grace_w);
	assign over_twice = (since > {grace_w[TIME_W-2:0], 1'b0});
	assign recon_due  = ({1'b0, item.now} >
		({1'b0, last_recon_q} + (TIME_W+1)'(cfg.interval_ticks)));

	// next state and result for the item
	always_comb begin
		oldest_slot_d = oldest_slot_q;
		outstanding_d = outstanding_q;
		oldest_seq_d  = oldest_seq_q;
		next_seq_d    = next_seq_q;
		last_acked_d  = last_acked_q;
		lag_end_d     = lag_end_q;
		last_recon_d  = last_recon_q;
		acked_once_d  = acked_once_q;
		lag_flag_d    = lag_flag_q;
		result        = '0;

		unique case (item.op)
			OP_SEND: begin
				if (item.healthy) begin
					next_seq_d = seq_inc;
					if (outstanding_q == '0) begin
						oldest_seq_d  = seq_inc;
						outstanding_d = CNT_W'(1);
					end else if (ring_full) begin
						oldest_seq_d          = oldest_seq_q + SEQ_W'(1);
						oldest_slot_d         = ring_wrap(SUM_W'(oldest_slot_q) + SUM_W'(1));
						result.dropped_oldest = 1'b1;
					end else begin
						outstanding_d = outstanding_q + CNT_W'(1);
					end
					result.sent     = 1'b1;
					result.sent_seq = seq_inc;
				end
			end
			OP_ACK: begin
				if (ack_hit) begin
					result.ack_matched = 1'b1;
					if (stamp_newer) begin
						last_acked_d      = stamp;
						acked_once_d      = 1'b1;
						result.round_trip = rtt;
						if (lag_flag_q && (rtt < grace_w)) begin
							lag_flag_d         = 1'b0;
							lag_end_d          = item.now;
							result.lag_cleared = 1'b1;
						end
					end else begin
						last_acked_d           = stale_time;
						lag_flag_d             = 1'b1;
						result.clock_backwards = 1'b1;
					end
					outstanding_d = outstanding_q - (off_c + CNT_W'(1));
					oldest_seq_d  = item.ack_seq + SEQ_W'(1);
					oldest_slot_d = adv_slot;
				end
			end
			OP_CHECK: begin
				if (acked_once_q && over_grace) begin
					lag_flag_d   = 1'b1;
					result.laggy = 1'b1;
					if (over_twice && recon_due) begin
						last_recon_d     = item.now;
						result.reconnect = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		result.lag_end_stamp = lag_end_d;
	end

	// control and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_slot_q <= '0;
			outstanding_q <= '0;
			oldest_seq_q  <= SEQ_W'(1);
			next_seq_q    <= '0;
			last_acked_q  <= '0;
			lag_end_q     <= '0;
			last_recon_q  <= '0;
			acked_once_q  <= 1'b0;
			lag_flag_q    <= 1'b0;
		end else if (step) begin
			oldest_slot_q <= oldest_slot_d;
			outstanding_q <= outstanding_d;
			oldest_seq_q  <= oldest_seq_d;
			next_seq_q    <= next_seq_d;
			last_acked_q  <= last_acked_d;
			lag_end_q     <= lag_end_d;
			last_recon_q  <= last_recon_d;
			acked_once_q  <= acked_once_d;
			lag_flag_q    <= lag_flag_d;
		end
	end

	// send stamps, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_ring_q[wr_slot] <= item.now;
		end
	end

endmodule

// ----- hw/rtl/heartbeat_lag_monitor.sv -----
// top level of the heartbeat lag monitor: handshakes, registers and core
`timescale 1ns / 1ps

// channel   direction  handshake                payload
// item      in         item_valid / item_stall  item_t (op, now, ack_seq, healthy)
// res       out        res_valid / res_stall    result_t
// apb       in/out     psel, penable, pready    grace_ticks @0x0, interval_ticks @0x4
//
// one result per item; an item is held in the input register until the result
// register can take its result, so a new transfer is taken
// every cycle while results keep draining
// the whole item is handled by one pass through the core between those registers
// reset clears the ring pointers, counters and flags; stamps need no clear
// a stalled result holds the input register, which then stalls the item side

module heartbeat_lag_monitor
	import hblm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        res_valid,
	input  logic        res_stall,
	output result_t     res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	cfg_t    cfg_q;
	logic    advance;
	logic    accept;
	logic    step;
	result_t result;

	// handshake between the two registers
	assign advance    = !valid_s2 || !res_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign step       = valid_s1 && advance;
	assign res_valid  = valid_s2;
	assign res        = res_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grace_ticks    <= GRACE_RST;
			cfg_q.interval_ticks <= INTERVAL_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				CFG_GRACE:    cfg_q.grace_ticks    <= pwdata[CFG_W-1:0];
				CFG_INTERVAL: cfg_q.interval_ticks <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			CFG_GRACE:    prdata = 32'(cfg_q.grace_ticks);
			CFG_INTERVAL: prdata = 32'(cfg_q.interval_ticks);
			default:      prdata = '0;
		endcase
	end

	hblm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

endmodule

// ----- bench/tb_heartbeat_lag_monitor.sv -----
`timescale 1ns / 1ps
// self-checking bench for the heartbeat lag monitor: directed cases, then random traffic
module tb_heartbeat_lag_monitor;
	import hblm_pkg::*;

	localparam logic [2:0]        ADDR_GRACE    = {CFG_GRACE, 2'b00};
	localparam logic [2:0]        ADDR_INTERVAL = {CFG_INTERVAL, 2'b00};
	localparam logic [1:0]        OP_UNUSED     = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX      = '1;
	localparam logic [SEQ_W-1:0]  SEQ_MAX       = '1;
	localparam int                DRAIN_CYCLES  = 4;
	localparam int                CHUNKS        = 11;
	localparam int                CHUNK_ITEMS   = 100;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        res_valid;
	logic        res_stall;
	result_t     res;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// tracker copy of the block state
	logic [TIME_W-1:0] stamp_copy [RING_DEPTH];
	logic [SEQ_W-1:0]  head_seq;
	logic [SEQ_W-1:0]  newest_seq;
	int unsigned       in_flight;
	int unsigned       head_slot;
	logic [TIME_W-1:0] acked_stamp;
	logic              seen_ack;
	logic              lagging;
	logic [TIME_W-1:0] lag_end;
	logic [TIME_W-1:0] reconnect_at;
	logic [CFG_W-1:0]  grace;
	logic [CFG_W-1:0]  interval;

	result_t due_outcomes [$];
	result_t wanted;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int error_count;
	int items_sent;
	int results_checked;
	int drop_count;
	int match_count;
	int stale_count;
	int clear_count;
	int reconnect_count;
	int settings_applied;

	heartbeat_lag_monitor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #2 clk = ~clk;

	// receiver stalls at random
	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// difference that stops at zero when time runs backwards
	function automatic logic [TIME_W-1:0] time_gap(input logic [TIME_W-1:0] later,
			input logic [TIME_W-1:0] earlier);
		return (later >= earlier) ? later - earlier : '0;
	endfunction

	// advance the tracker by one item and return the result it causes
	function automatic result_t track_heartbeat(input item_t it);
		result_t           r;
		logic [SEQ_W-1:0]  off;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] rtt;
		logic [TIME_W-1:0] since;
		int unsigned       slot;
		r = '0;
		case (it.op)
			OP_SEND: begin
				if (it.healthy) begin
					newest_seq = newest_seq + 1'b1;
					if (in_flight == 0) begin
						head_seq = newest_seq;
					end else if (in_flight >= RING_DEPTH) begin
						// ring full, oldest beacon gives way
						head_seq = head_seq + 1'b1;
						head_slot = (head_slot + 1) % RING_DEPTH;
						in_flight--;
						r.dropped_oldest = 1'b1;
					end
					slot = (head_slot + in_flight) % RING_DEPTH;
					stamp_copy[slot[IDX_W-1:0]] = it.now;
					in_flight++;
					r.sent = 1'b1;
					r.sent_seq = newest_seq;
				end
			end
			OP_ACK: begin
				off = it.ack_seq - head_seq;
				if (in_flight != 0 && off < in_flight) begin
					slot = (head_slot + off) % RING_DEPTH;
					stamp = stamp_copy[slot[IDX_W-1:0]];
					r.ack_matched = 1'b1;
					if (!seen_ack || stamp > acked_stamp) begin
						rtt = time_gap(it.now, stamp);
						acked_stamp = stamp;
						seen_ack = 1'b1;
						r.round_trip = rtt;
						if (lagging && rtt < grace) begin
							lagging = 1'b0;
							lag_end = it.now;
							r.lag_cleared = 1'b1;
						end
					end else begin
						// stale stamp, clock went backwards
						acked_stamp = time_gap(it.now,
							TIME_W'(grace) + TIME_W'(TICKS_PER_SECOND));
						lagging = 1'b1;
						r.clock_backwards = 1'b1;
					end
					// retire everything up to the acknowledged beacon
					in_flight = in_flight - (off + 1);
					head_seq = it.ack_seq + 1'b1;
					head_slot = (head_slot + off + 1) % RING_DEPTH;
				end
			end
			OP_CHECK: begin
				if (seen_ack) begin
					since = time_gap(it.now, acked_stamp);
					if (since > grace) begin
						lagging = 1'b1;
						r.laggy = 1'b1;
						if (since > {grace, 1'b0} &&
								{16'd0, it.now} > {16'd0, reconnect_at} + interval) begin
							reconnect_at = it.now;
							r.reconnect = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.lag_end_stamp = lag_end;
		return r;
	endfunction

	function automatic item_t make_item(input logic [1:0] op, input logic [TIME_W-1:0] now,
			input logic [SEQ_W-1:0] seq, input logic healthy);
		item_t it;
		it.op = op;
		it.now = now;
		it.ack_seq = seq;
		it.healthy = healthy;
		return it;
	endfunction

	// acks mostly land inside the outstanding window
	function automatic logic [SEQ_W-1:0] pick_ack_seq();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (in_flight != 0 && pick < 75) begin
			return head_seq + $urandom_range(0, in_flight - 1);
		end
		if (pick < 85) begin
			return newest_seq + $urandom_range(0, 1);
		end
		if (pick < 93) begin
			return head_seq - $urandom_range(1, 3);
		end
		return $urandom;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// one item transfer, then an optional sender gap
	task automatic send_item(input item_t it);
		result_t r;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		r = track_heartbeat(it);
		due_outcomes.push_back(r);
		items_sent++;
		drop_count += r.dropped_oldest;
		match_count += r.ack_matched;
		stale_count += r.clock_backwards;
		clear_count += r.lag_cleared;
		reconnect_count += r.reconnect;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		end
	endtask

	// hold the sender until every result has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (due_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_register(input logic [2:0] addr, output logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only with the block idle
	task automatic apply_config(input logic [CFG_W-1:0] new_grace,
			input logic [CFG_W-1:0] new_interval);
		logic [31:0] readback;
		wait_drained();
		write_register(ADDR_GRACE, {12'd0, new_grace});
		write_register(ADDR_INTERVAL, {12'd0, new_interval});
		grace = new_grace;
		interval = new_interval;
		settings_applied++;
		read_register(ADDR_GRACE, readback);
		compare_field("grace_ticks readback", 64'(new_grace), 64'(readback));
		read_register(ADDR_INTERVAL, readback);
		compare_field("interval_ticks readback", 64'(new_interval), 64'(readback));
	endtask

	// nothing outstanding, unused code, skipped send
	task automatic test_idle_state();
		send_item(make_item(OP_CHECK, TIME_MAX, SEQ_MAX, 1'b1));
		send_item(make_item(OP_UNUSED, TIME_MAX, SEQ_MAX, 1'b1));
		send_item(make_item(OP_SEND, TIME_W'(1000), SEQ_MAX, 1'b0));
	endtask

	// one beacon more than the ring holds
	task automatic test_ring_overflow();
		for (int k = 0; k <= RING_DEPTH; k++) begin
			send_item(make_item(OP_SEND, TIME_W'(2000 + 10 * k), '0, 1'b1));
		end
		// the pushed-out beacon no longer matches
		send_item(make_item(OP_ACK, TIME_W'(2200), 32'd1, 1'b1));
	endtask

	// first ack, lag with reconnect, then a timely ack ends the lag
	task automatic test_lag_recovery();
		send_item(make_item(OP_ACK, TIME_W'(2300), 32'd3, 1'b1));
		send_item(make_item(OP_CHECK, TIME_W'(32021), '0, 1'b1));
		send_item(make_item(OP_ACK, TIME_W'(2100), 32'd5, 1'b1));
	endtask

	// backward time, stale stamp, recovery at the top of the time range
	task automatic test_clock_steps();
		send_item(make_item(OP_ACK, TIME_W'(10), 32'd6, 1'b1));
		send_item(make_item(OP_SEND, TIME_W'(100), '0, 1'b1));
		send_item(make_item(OP_ACK, TIME_W'(200), 32'd18, 1'b1));
		send_item(make_item(OP_CHECK, TIME_W'(40000), '0, 1'b1));
		send_item(make_item(OP_SEND, TIME_MAX - 5, '0, 1'b1));
		send_item(make_item(OP_ACK, TIME_MAX, 32'd19, 1'b0));
	endtask

	// random traffic over a sweep of register settings and idle patterns
	task automatic test_random_traffic();
		item_t             it;
		logic [TIME_W-1:0] clock_now;
		int unsigned       pick;
		int unsigned       ack_pct;
		int unsigned       step_max;
		clock_now = TIME_W'(50000);
		for (int c = 0; c < CHUNKS; c++) begin
			case (c)
				0: apply_config(CFG_W'(1), CFG_W'(1));
				1: apply_config(CFG_W'(1000000), CFG_W'(1000000));
				2: apply_config(CFG_W'(1), CFG_W'(1000000));
				3: apply_config(CFG_W'(1000000), CFG_W'(1));
				CHUNKS - 1: apply_config(GRACE_RST, INTERVAL_RST);
				default: apply_config(
					CFG_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 1000000 : 300)),
					CFG_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 1000000 : 2000)));
			endcase
			if (c < 4) begin
				send_idle_pct = 9;
				recv_idle_pct = 56;
			end else if (c < 8) begin
				send_idle_pct = 56;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			ack_pct = $urandom_range(10, 40);
			step_max = 3 * grace + 2;
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				// time mostly moves forward, with holds, steps back and jumps
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					clock_now = clock_now + $urandom_range(0, step_max);
				end else if (pick >= 88 && pick < 95) begin
					clock_now = clock_now - $urandom_range(0, step_max);
				end else if (pick >= 95 && pick < 98) begin
					clock_now = TIME_W'({$urandom, $urandom});
				end else if (pick >= 98) begin
					clock_now = TIME_MAX - $urandom_range(0, step_max);
				end
				it.now = clock_now;
				it.healthy = ($urandom_range(0, 9) != 0);
				it.ack_seq = $urandom;
				pick = $urandom_range(0, 99);
				if (pick < ack_pct) begin
					it.op = OP_ACK;
					it.ack_seq = pick_ack_seq();
				end else if (pick < ack_pct + 25) begin
					it.op = OP_CHECK;
				end else if (pick < 96) begin
					it.op = OP_SEND;
				end else if (pick < 97) begin
					it.op = OP_UNUSED;
				end else begin
					// noise over the whole field range
					it.op = 2'($urandom_range(0, 3));
					it.now = TIME_W'({$urandom, $urandom});
					it.healthy = 1'($urandom_range(0, 1));
				end
				send_item(it);
				if ((c == 2 && n == CHUNK_ITEMS / 2) || $urandom_range(0, 199) == 0) begin
					wait_drained();
				end
			end
		end
	endtask

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (due_outcomes.size() == 0) begin
				$display("%0t: result transfer with none expected, actual %0h", $time, res);
				error_count++;
			end else begin
				wanted = due_outcomes.pop_front();
				results_checked++;
				compare_field("sent", 64'(wanted.sent), 64'(res.sent));
				compare_field("sent_seq", 64'(wanted.sent_seq), 64'(res.sent_seq));
				compare_field("dropped_oldest", 64'(wanted.dropped_oldest),
					64'(res.dropped_oldest));
				compare_field("ack_matched", 64'(wanted.ack_matched), 64'(res.ack_matched));
				compare_field("round_trip", 64'(wanted.round_trip), 64'(res.round_trip));
				compare_field("clock_backwards", 64'(wanted.clock_backwards),
					64'(res.clock_backwards));
				compare_field("lag_cleared", 64'(wanted.lag_cleared), 64'(res.lag_cleared));
				compare_field("laggy", 64'(wanted.laggy), 64'(res.laggy));
				compare_field("reconnect", 64'(wanted.reconnect), 64'(res.reconnect));
				compare_field("lag_end_stamp", 64'(wanted.lag_end_stamp),
					64'(res.lag_end_stamp));
			end
		end
	end

	// run watchdog
	initial begin
		#2000000;
		$display("tb_heartbeat_lag_monitor: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		res_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		head_seq = 32'd1;
		newest_seq = '0;
		in_flight = 0;
		head_slot = 0;
		acked_stamp = '0;
		seen_ack = 1'b0;
		lagging = 1'b0;
		lag_end = '0;
		reconnect_at = '0;
		grace = GRACE_RST;
		interval = INTERVAL_RST;
		send_idle_pct = 9;
		recv_idle_pct = 56;
		error_count = 0;
		items_sent = 0;
		results_checked = 0;
		drop_count = 0;
		match_count = 0;
		stale_count = 0;
		clear_count = 0;
		reconnect_count = 0;
		settings_applied = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_state();
		test_ring_overflow();
		test_lag_recovery();
		test_clock_steps();
		test_random_traffic();
		wait_drained();
		$display("covered %0d items, %0d results checked, %0d register settings",
			items_sent, results_checked, settings_applied);
		$display("%0d ring drops, %0d matched acks, %0d stale stamps, %0d lag clears, %0d reconnects",
			drop_count, match_count, stale_count, clear_count, reconnect_count);
		if (error_count == 0) begin
			$display("tb_heartbeat_lag_monitor: clean");
		end else begin
			$display("tb_heartbeat_lag_monitor: errors");
		end
		$finish;
	end

endmodule
